### design/mic_pkg.sv
// ----------------------------------------------------------------------------
// mic_pkg
// Shared constants and helpers for the message identifier cipher.
// ----------------------------------------------------------------------------
package mic_pkg;

    localparam int ID_W        = 16;
    localparam int DEV_W       = 24;
    localparam int ROUNDS      = 32;
    localparam int NIBBLE_SPAN = 13;
    localparam int POS_W       = 4;

    localparam logic [3:0] SBOX [16] = '{
        4'h1, 4'h0, 4'hC, 4'h8, 4'hA, 4'h9, 4'hE, 4'h7,
        4'h3, 4'h5, 4'h4, 4'hB, 4'h2, 4'hF, 4'h6, 4'hD
    };

    typedef logic [ID_W-1:0] id_t;

    // substitute the nibble starting at bit pos
    function automatic id_t sub_nibble(input id_t v, input logic [POS_W-1:0] pos);
        id_t        mask;
        logic [3:0] nib;
        mask = id_t'(16'hF) << pos;
        nib  = 4'((v >> pos) & id_t'(16'hF));
        return (v & ~mask) | (id_t'(SBOX[nib]) << pos);
    endfunction

    // low byte: dev[7:0] ^ dev[23:16], high byte: dev[15:8]
    function automatic id_t make_key(input logic [DEV_W-1:0] dev);
        return {dev[15:8], dev[7:0] ^ dev[23:16]};
    endfunction

endpackage

### design/mic_round.sv
// ----------------------------------------------------------------------------
// mic_round
// One cipher round: substitute then XOR key (encode), or XOR key then
// substitute (decode).
// ----------------------------------------------------------------------------
module mic_round (
    input  mic_pkg::id_t               x_in,
    input  mic_pkg::id_t               key,
    input  logic [mic_pkg::POS_W-1:0]  enc_pos,
    input  logic [mic_pkg::POS_W-1:0]  dec_pos,
    input  logic                       decode,
    output mic_pkg::id_t               x_out
);
    import mic_pkg::*;

    always_comb begin
        if (decode) begin
            x_out = sub_nibble(x_in ^ key, dec_pos);
        end else begin
            x_out = sub_nibble(x_in, enc_pos) ^ key;
        end
    end

endmodule

### design/mic_core.sv
// ----------------------------------------------------------------------------
// mic_core
// Chain of 32 rounds shared by encode and decode; decode walks the
// nibble positions in reverse order.
// ----------------------------------------------------------------------------
module mic_core (
    input  mic_pkg::id_t x_in,
    input  mic_pkg::id_t key,
    input  logic         decode,
    output mic_pkg::id_t x_out
);
    import mic_pkg::*;

    id_t chain [ROUNDS+1];

    assign chain[0] = x_in;

    for (genvar i = 0; i < ROUNDS; i++) begin : g_round
        localparam logic [POS_W-1:0] EPOS = POS_W'(i % NIBBLE_SPAN);
        localparam logic [POS_W-1:0] DPOS = POS_W'((ROUNDS - 1 - i) % NIBBLE_SPAN);

        mic_round u_round (
            .x_in    (chain[i]),
            .key     (key),
            .enc_pos (EPOS),
            .dec_pos (DPOS),
            .decode  (decode),
            .x_out   (chain[i+1])
        );
    end

    assign x_out = chain[ROUNDS];

endmodule

### design/message_id_sbox_cipher.sv
// ----------------------------------------------------------------------------
// message_id_sbox_cipher
// Obscures 16-bit message identifiers with a keyed nibble-substitution cipher.
// ----------------------------------------------------------------------------
// Input stream (s_*): one transaction per request. s_tuser is the request
// type (0 = encode the next counter value, 1 = decode s_tdata coded id).
// Output stream (m_*): exactly one transaction per request, in order.
// Encode requests bump the 16-bit message counter at acceptance; the counter
// skips zero on wrap. Decode requests leave it unchanged.
// The result passes through the input register, 32 unrolled rounds and the
// result register.
// Throughput: one transaction per cycle while m_tready is high.
// When the receiver stalls, the result register and input register hold;
// s_tready drops only when both are full and m_tready is low.
// Reset (aresetn low, synchronous) empties the pipeline and clears the
// counter to zero.
// ----------------------------------------------------------------------------
module message_id_sbox_cipher (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // device_id[23:0], coded_id[39:24]
    input  logic        s_tuser,   // req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // id_out[15:0], sequence_value[31:16]
);
    import mic_pkg::*;

    localparam logic REQ_ENCODE = 1'b0;

    logic         cnt_en;
    id_t          cnt_reg, cnt_next, cnt_inc;

    logic         st_valid_reg, st_valid_next;
    logic         st_dec_reg;
    id_t          st_x_reg, st_key_reg, st_seq_reg;

    logic         out_valid_reg, out_valid_next;
    id_t          out_id_reg, out_seq_reg;

    logic         out_ready, st_ready, s_accept, st_move;
    id_t          core_out;

    assign out_ready = !out_valid_reg || m_tready;
    assign st_ready  = !st_valid_reg || out_ready;
    assign s_tready  = st_ready;
    assign s_accept  = s_tvalid && st_ready;
    assign st_move   = st_valid_reg && out_ready;

    assign cnt_inc  = cnt_reg + id_t'(1);
    assign cnt_en   = s_accept && (s_tuser == REQ_ENCODE);
    assign cnt_next = (cnt_inc == '0) ? id_t'(1) : cnt_inc;

    always_comb begin
        st_valid_next = st_valid_reg;
        if (st_ready) begin
            st_valid_next = s_tvalid;
        end
        out_valid_next = out_valid_reg;
        if (out_ready) begin
            out_valid_next = st_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg       <= '0;
            st_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cnt_en) begin
                cnt_reg <= cnt_next;
            end
            st_valid_reg  <= st_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            st_dec_reg <= s_tuser;
            st_key_reg <= make_key(s_tdata[23:0]);
            st_x_reg   <= (s_tuser == REQ_ENCODE) ? cnt_next : s_tdata[39:24];
            st_seq_reg <= (s_tuser == REQ_ENCODE) ? cnt_next : cnt_reg;
        end
        if (st_move) begin
            out_id_reg  <= core_out;
            out_seq_reg <= st_seq_reg;
        end
    end

    mic_core u_core (
        .x_in   (st_x_reg),
        .key    (st_key_reg),
        .decode (st_dec_reg),
        .x_out  (core_out)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_seq_reg, out_id_reg};

endmodule
